// ----- hw/rtl/ridtt_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ridtt_pkg
// Shared constants and types of the request id translation table.
// ----------------------------------------------------------------------------
package ridtt_pkg;

    // table geometry
    localparam int TABLE_SIZE = 64;
    localparam int SLOT_W     = $clog2(TABLE_SIZE);

    // field widths
    localparam int TID_W  = 7;
    localparam int TIME_W = 10;
    localparam int MOD_W  = 11;
    localparam int TTL_W  = 10;
    localparam int ID_W   = 16;
    localparam int IP_W   = 32;
    localparam int PORT_W = 16;

    // configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 11;
    localparam logic [CFG_IDX_W-1:0] CFG_TTL      = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIME_MOD = 1'b1;
    localparam logic [TTL_W-1:0] TTL_RESET      = 10'd10;
    localparam logic [MOD_W-1:0] TIME_MOD_RESET = 11'd1000;
    localparam logic [MOD_W-1:0] MOD_MIN        = 11'd2;

    // request kinds
    localparam logic KIND_ALLOC  = 1'b0;
    localparam logic KIND_LOOKUP = 1'b1;

    // remainder unit: one quotient bit per step
    localparam int DIV_STEPS = TIME_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

    // one table entry as held in the slot memory
    typedef struct packed {
        logic [TIME_W-1:0] stamp;
        logic [ID_W-1:0]   saved_id;
        logic [IP_W-1:0]   saved_ip;
        logic [PORT_W-1:0] saved_port;
    } entry_t;

    // one result item
    typedef struct packed {
        logic [TID_W-1:0]  trans_id;
        logic              found;
        logic [ID_W-1:0]   orig_id;
        logic [IP_W-1:0]   orig_ip;
        logic [PORT_W-1:0] orig_port;
    } rsp_item_t;

    // sequencer states
    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_NMOD  = 8'b0000_0010,
        ST_READ  = 8'b0000_0100,
        ST_SCAN  = 8'b0000_1000,
        ST_SMOD  = 8'b0001_0000,
        ST_LREAD = 8'b0010_0000,
        ST_LDATA = 8'b0100_0000,
        ST_FIN   = 8'b1000_0000
    } state_t;

endpackage

// ----- hw/rtl/ridtt_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ridtt_if
// Request and response channel interfaces of the translation table.
// ----------------------------------------------------------------------------

// request channel
interface ridtt_req_if import ridtt_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              kind;
    logic [TIME_W-1:0] now;
    logic [ID_W-1:0]   id_value;
    logic [IP_W-1:0]   client_ip;
    logic [PORT_W-1:0] client_port;

    modport source (output valid, kind, now, id_value, client_ip, client_port,
                    input ready);
    modport sink   (input valid, kind, now, id_value, client_ip, client_port,
                    output ready);
endinterface

// response channel
interface ridtt_rsp_if import ridtt_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [TID_W-1:0]  trans_id;
    logic              found;
    logic [ID_W-1:0]   orig_id;
    logic [IP_W-1:0]   orig_ip;
    logic [PORT_W-1:0] orig_port;

    modport source (output valid, trans_id, found, orig_id, orig_ip, orig_port,
                    input ready);
    modport sink   (input valid, trans_id, found, orig_id, orig_ip, orig_port,
                    output ready);
endinterface

// ----- hw/rtl/request_id_translation_table_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// request_id_translation_table_top
// Relay id translation table: round-robin slot allocation with ageing,
// and lookup of a translated id back to the stored client entry.
// ----------------------------------------------------------------------------
//  channel   dir  handshake      payload
//  req       in   valid/ready    kind, now, id_value, client_ip, client_port
//  rsp       out  valid/ready    trans_id, found, orig_id, orig_ip, orig_port
//  cfg       in   cfg_we         cfg_index, cfg_data (ttl, time_mod)
//
//  allocate: scans from the round-robin slot, one slot per cycle over the slot
//  memory read port while no stamp needs reducing; the shared remainder unit
//  reduces now when it is at or above the modulus and the stamp of each busy
//  slot visited whose stamp is. lookup: reads the slot named by the id.
//  req is ready only in idle; a stalled rsp holds the next result in the finish
//  state. Reset clears the busy map at once, no sweep.
// ----------------------------------------------------------------------------
module request_id_translation_table_top import ridtt_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    ridtt_req_if.sink             req,
    ridtt_rsp_if.source           rsp
);

    // control state
    state_t                state_reg, state_next;
    logic [TABLE_SIZE-1:0] busy_reg, busy_next;
    logic [SLOT_W-1:0]     next_slot_reg, next_slot_next;
    logic [SLOT_W-1:0]     ptr_reg, ptr_next;
    logic [SLOT_W-1:0]     cnt_reg, cnt_next;
    logic [TTL_W-1:0]      ttl_reg;
    logic [MOD_W-1:0]      time_mod_reg;
    logic                  out_valid_reg, out_valid_next;
    logic [DIV_CNT_W-1:0]  div_cnt_reg, div_cnt_next;

    // payload state
    logic [TIME_W-1:0] now_reg, now_next;
    logic [TIME_W-1:0] a_reg, a_next;
    logic [ID_W-1:0]   id_reg, id_next;
    logic [IP_W-1:0]   ip_reg, ip_next;
    logic [PORT_W-1:0] port_reg, port_next;
    logic              lk_ok_reg, lk_ok_next;
    rsp_item_t         res_reg, res_next;
    rsp_item_t         out_reg;
    logic [TIME_W-1:0] div_x_reg, div_x_next;
    logic [MOD_W-1:0]  div_rem_reg, div_rem_next;

    // slot memory
    entry_t            mem [TABLE_SIZE];
    entry_t            rd_data_reg;
    logic              mem_we;
    logic [SLOT_W-1:0] mem_ra;
    entry_t            mem_wd;

    // effective modulus, never below two
    logic [MOD_W-1:0] mod_eff;
    assign mod_eff = (time_mod_reg < MOD_MIN) ? MOD_MIN : time_mod_reg;

    // remainder unit step
    logic [MOD_W:0]   div_trial;
    logic [MOD_W:0]   div_sub;
    logic [MOD_W-1:0] div_rem_step;
    logic             div_done;
    assign div_trial    = {div_rem_reg, div_x_reg[TIME_W-1]};
    assign div_sub      = div_trial - {1'b0, mod_eff};
    assign div_rem_step = (div_trial >= {1'b0, mod_eff}) ? div_sub[MOD_W-1:0]
                                                         : div_trial[MOD_W-1:0];
    assign div_done     = (div_cnt_reg == DIV_CNT_W'(DIV_STEPS));

    // age of the slot under test and expiry compare
    logic [TIME_W-1:0] b_val;
    logic [MOD_W:0]    a_ext, b_ext, age;
    logic              expired;
    logic              stamp_big;
    assign b_val     = (state_reg == ST_SMOD) ? div_rem_reg[TIME_W-1:0]
                                              : rd_data_reg.stamp;
    assign a_ext     = {2'b00, a_reg};
    assign b_ext     = {2'b00, b_val};
    assign age       = (a_ext >= b_ext) ? (a_ext - b_ext)
                                        : (a_ext + {1'b0, mod_eff} - b_ext);
    assign expired   = (age > {2'b00, ttl_reg});
    assign stamp_big = ({1'b0, rd_data_reg.stamp} >= mod_eff);

    // scan pointer arithmetic
    logic [SLOT_W-1:0] ptr_inc;
    logic              scan_last;
    logic [ID_W-1:0]   id_minus;
    logic              out_free;
    assign ptr_inc   = (ptr_reg == SLOT_W'(TABLE_SIZE - 1)) ? '0 : ptr_reg + 1'b1;
    assign scan_last = (cnt_reg == SLOT_W'(TABLE_SIZE - 1));
    assign id_minus  = req.id_value - 1'b1;
    assign out_free  = !out_valid_reg || rsp.ready;

    assign req.ready = (state_reg == ST_IDLE);

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        busy_next      = busy_reg;
        next_slot_next = next_slot_reg;
        ptr_next       = ptr_reg;
        cnt_next       = cnt_reg;
        now_next       = now_reg;
        a_next         = a_reg;
        id_next        = id_reg;
        ip_next        = ip_reg;
        port_next      = port_reg;
        lk_ok_next     = lk_ok_reg;
        res_next       = res_reg;
        div_x_next     = div_x_reg;
        div_rem_next   = div_rem_reg;
        div_cnt_next   = div_cnt_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        mem_we         = 1'b0;
        mem_ra         = ptr_reg;
        mem_wd         = '{stamp: now_reg, saved_id: id_reg,
                           saved_ip: ip_reg, saved_port: port_reg};

        // remainder unit runs while a reduction state waits on it
        if ((state_reg == ST_NMOD || state_reg == ST_SMOD) && !div_done)
        begin
            div_rem_next = div_rem_step;
            div_x_next   = {div_x_reg[TIME_W-2:0], 1'b0};
            div_cnt_next = div_cnt_reg + 1'b1;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    now_next  = req.now;
                    id_next   = req.id_value;
                    ip_next   = req.client_ip;
                    port_next = req.client_port;
                    cnt_next  = '0;
                    if (req.kind == KIND_ALLOC)
                    begin
                        ptr_next = next_slot_reg;
                        if ({1'b0, req.now} >= mod_eff)
                        begin
                            div_x_next   = req.now;
                            div_rem_next = '0;
                            div_cnt_next = '0;
                            state_next   = ST_NMOD;
                        end
                        else
                        begin
                            a_next     = req.now;
                            state_next = ST_READ;
                        end
                    end
                    else
                    begin
                        lk_ok_next = (req.id_value != '0) &&
                                     (req.id_value <= ID_W'(TABLE_SIZE));
                        ptr_next   = id_minus[SLOT_W-1:0];
                        state_next = ST_LREAD;
                    end
                end
            end
            ST_NMOD:
            begin
                if (div_done)
                begin
                    a_next     = div_rem_reg[TIME_W-1:0];
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                mem_ra     = ptr_reg;
                state_next = ST_SCAN;
            end
            ST_SCAN, ST_SMOD:
            begin
                if (state_reg == ST_SMOD && !div_done)
                begin
                    state_next = ST_SMOD;
                end
                else if (state_reg == ST_SCAN && busy_reg[ptr_reg] && stamp_big)
                begin
                    // stamp needs reducing first
                    div_x_next   = rd_data_reg.stamp;
                    div_rem_next = '0;
                    div_cnt_next = '0;
                    state_next   = ST_SMOD;
                end
                else if (!busy_reg[ptr_reg] || expired)
                begin
                    // take this slot
                    mem_we            = 1'b1;
                    busy_next[ptr_reg] = 1'b1;
                    next_slot_next    = ptr_inc;
                    res_next          = '0;
                    res_next.trans_id = TID_W'(ptr_reg) + TID_W'(1);
                    state_next        = ST_FIN;
                end
                else if (scan_last)
                begin
                    // table full
                    res_next   = '0;
                    state_next = ST_FIN;
                end
                else
                begin
                    ptr_next = ptr_inc;
                    cnt_next = cnt_reg + 1'b1;
                    mem_ra   = ptr_inc;
                    state_next = (state_reg == ST_SCAN) ? ST_SCAN : ST_READ;
                end
            end
            ST_LREAD:
            begin
                mem_ra     = ptr_reg;
                state_next = ST_LDATA;
            end
            ST_LDATA:
            begin
                res_next = '0;
                if (lk_ok_reg && busy_reg[ptr_reg])
                begin
                    res_next.found     = 1'b1;
                    res_next.orig_id   = rd_data_reg.saved_id;
                    res_next.orig_ip   = rd_data_reg.saved_ip;
                    res_next.orig_port = rd_data_reg.saved_port;
                end
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            busy_reg      <= '0;
            next_slot_reg <= '0;
            ptr_reg       <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            div_cnt_reg   <= '0;
            ttl_reg       <= TTL_RESET;
            time_mod_reg  <= TIME_MOD_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            busy_reg      <= busy_next;
            next_slot_reg <= next_slot_next;
            ptr_reg       <= ptr_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            div_cnt_reg   <= div_cnt_next;
            if (cfg_we && cfg_index == CFG_TTL)
            begin
                ttl_reg <= cfg_data[TTL_W-1:0];
            end
            if (cfg_we && cfg_index == CFG_TIME_MOD)
            begin
                time_mod_reg <= cfg_data[MOD_W-1:0];
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        now_reg     <= now_next;
        a_reg       <= a_next;
        id_reg      <= id_next;
        ip_reg      <= ip_next;
        port_reg    <= port_next;
        lk_ok_reg   <= lk_ok_next;
        res_reg     <= res_next;
        div_x_reg   <= div_x_next;
        div_rem_reg <= div_rem_next;
        if (state_reg == ST_FIN && out_free)
        begin
            out_reg <= res_reg;
        end
    end

    // slot memory, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[ptr_reg] <= mem_wd;
        end
        rd_data_reg <= mem[mem_ra];
    end

    // response outputs
    assign rsp.valid     = out_valid_reg;
    assign rsp.trans_id  = out_reg.trans_id;
    assign rsp.found     = out_reg.found;
    assign rsp.orig_id   = out_reg.orig_id;
    assign rsp.orig_ip   = out_reg.orig_ip;
    assign rsp.orig_port = out_reg.orig_port;

endmodule

// ----- hw/rtl/ridtt_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ridtt_checker
// Port-level checks of the translation table, bound to the top level.
// ----------------------------------------------------------------------------
module ridtt_checker import ridtt_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              req_valid,
    input logic              req_ready,
    input logic              rsp_valid,
    input logic              rsp_ready,
    input logic [TID_W-1:0]  rsp_trans_id,
    input logic              rsp_found,
    input logic [ID_W-1:0]   rsp_orig_id,
    input logic [IP_W-1:0]   rsp_orig_ip,
    input logic [PORT_W-1:0] rsp_orig_port
);

    // one transaction in flight: busy right after a request is taken
    a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> !req_ready)
        else $error("request taken while previous transaction in flight");

    // stalled response holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_trans_id) &&
                                       $stable(rsp_found) && $stable(rsp_orig_ip)))
        else $error("stalled response changed");

    // a lookup hit never carries a translated id
    a_hit_no_tid: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_found) |-> (rsp_trans_id == '0))
        else $error("lookup hit with translated id");

    // a miss or allocate carries no stored entry
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_found) |-> (rsp_orig_id == '0 && rsp_orig_ip == '0 &&
                                       rsp_orig_port == '0))
        else $error("entry fields set without lookup hit");

    // translated id stays within the table
    a_tid_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> ({1'b0, rsp_trans_id} <= (TID_W + 1)'(TABLE_SIZE)))
        else $error("translated id beyond table");

endmodule

bind request_id_translation_table_top ridtt_checker u_ridtt_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .req_valid     (req.valid),
    .req_ready     (req.ready),
    .rsp_valid     (rsp.valid),
    .rsp_ready     (rsp.ready),
    .rsp_trans_id  (rsp.trans_id),
    .rsp_found     (rsp.found),
    .rsp_orig_id   (rsp.orig_id),
    .rsp_orig_ip   (rsp.orig_ip),
    .rsp_orig_port (rsp.orig_port)
);

// ----- sim/request_id_translation_table_top_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// request_id_translation_table_top_tb
// Self-checking bench for the relay id translation table. A driver feeds
// allocate and lookup transactions from a backlog; a table image in the
// bench computes each reply when its request is accepted, and a monitor
// compares every reply field by field. Phases run under several ttl and
// modulus settings, with random gaps and back pressure on both channels.
// ----------------------------------------------------------------------------
module request_id_translation_table_top_tb;
    import ridtt_pkg::*;

    localparam int HOLD_CYCLES = 400;

    // one request as the bench keeps it
    typedef struct packed {
        logic              kind;
        logic [TIME_W-1:0] now;
        logic [ID_W-1:0]   id_value;
        logic [IP_W-1:0]   client_ip;
        logic [PORT_W-1:0] client_port;
    } req_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  hold_kick;
    int unsigned           hold_left;
    int                    snd_idle_pct;
    int                    rcv_idle_pct;
    int                    mismatches;

    ridtt_req_if req_ch();
    ridtt_rsp_if rsp_ch();

    request_id_translation_table_top dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req_ch),
        .rsp       (rsp_ch)
    );

    // requests not yet offered, replies not yet seen
    req_t      req_backlog[$];
    rsp_item_t reply_backlog[$];

    // table image
    logic              slot_busy  [TABLE_SIZE];
    logic [TIME_W-1:0] slot_stamp [TABLE_SIZE];
    logic [ID_W-1:0]   slot_qid   [TABLE_SIZE];
    logic [IP_W-1:0]   slot_ip    [TABLE_SIZE];
    logic [PORT_W-1:0] slot_port  [TABLE_SIZE];
    int unsigned       scan_ptr;
    int unsigned       age_limit;
    int unsigned       wrap_mod;
    int unsigned       clock_now;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // elapsed ticks between stamp and now on the wrapping counter
    function automatic int unsigned ticks_since(int unsigned t, int unsigned s);
        int unsigned m;
        m = (wrap_mod < 2) ? 2 : wrap_mod;
        return ((t % m) + m - (s % m)) % m;
    endfunction

    // apply one request to the table image and return its reply
    function automatic rsp_item_t table_access(req_t r);
        rsp_item_t   res;
        int unsigned s;
        logic        taken;
        res   = '0;
        taken = 1'b0;
        if (r.kind == KIND_ALLOC)
        begin
            s = scan_ptr;
            for (int n = 0; n < TABLE_SIZE && !taken; n++)
            begin
                // a visited busy slot past its age limit is released first
                if (slot_busy[s] && ticks_since(r.now, slot_stamp[s]) > age_limit)
                    slot_busy[s] = 1'b0;
                if (!slot_busy[s])
                begin
                    slot_busy[s]  = 1'b1;
                    slot_stamp[s] = r.now;
                    slot_qid[s]   = r.id_value;
                    slot_ip[s]    = r.client_ip;
                    slot_port[s]  = r.client_port;
                    res.trans_id  = TID_W'(s + 1);
                    scan_ptr      = (s + 1) % TABLE_SIZE;
                    taken         = 1'b1;
                end
                else
                    s = (s + 1) % TABLE_SIZE;
            end
        end
        else if (r.id_value != 0 && r.id_value <= TABLE_SIZE)
        begin
            s = r.id_value - 1;
            if (slot_busy[s])
            begin
                res.found     = 1'b1;
                res.orig_id   = slot_qid[s];
                res.orig_ip   = slot_ip[s];
                res.orig_port = slot_port[s];
            end
        end
        return res;
    endfunction

    task automatic compare_field(string fname, longint unsigned want, longint unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0h, actual %0h", fname, want, got);
            mismatches++;
        end
    endtask

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        req_t bus_item;
        req_t nxt;
        if (!rst_n)
        begin
            req_ch.valid <= 1'b0;
        end
        else
        begin
            // accepted transaction updates the table image
            if (req_ch.valid && req_ch.ready)
            begin
                bus_item.kind        = req_ch.kind;
                bus_item.now         = req_ch.now;
                bus_item.id_value    = req_ch.id_value;
                bus_item.client_ip   = req_ch.client_ip;
                bus_item.client_port = req_ch.client_port;
                reply_backlog.push_back(table_access(bus_item));
            end
            if (!req_ch.valid || req_ch.ready)
            begin
                if (req_backlog.size() != 0 && $urandom_range(0, 99) >= snd_idle_pct)
                begin
                    nxt = req_backlog.pop_front();
                    req_ch.valid       <= 1'b1;
                    req_ch.kind        <= nxt.kind;
                    req_ch.now         <= nxt.now;
                    req_ch.id_value    <= nxt.id_value;
                    req_ch.client_ip   <= nxt.client_ip;
                    req_ch.client_port <= nxt.client_port;
                end
                else
                    req_ch.valid <= 1'b0;
            end
        end
    end

    // long receiver hold-off counter
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hold_left <= 0;
        else if (hold_kick)
            hold_left <= HOLD_CYCLES;
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // response monitor
    always @(posedge clk or negedge rst_n)
    begin
        rsp_item_t want;
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
        end
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (reply_backlog.size() == 0)
                begin
                    $error("response transaction with no request outstanding");
                    mismatches++;
                end
                else
                begin
                    want = reply_backlog.pop_front();
                    compare_field("trans_id", want.trans_id, rsp_ch.trans_id);
                    compare_field("found", want.found, rsp_ch.found);
                    compare_field("orig_id", want.orig_id, rsp_ch.orig_id);
                    compare_field("orig_ip", want.orig_ip, rsp_ch.orig_ip);
                    compare_field("orig_port", want.orig_port, rsp_ch.orig_port);
                end
            end
            rsp_ch.ready <= (hold_left == 0) && ($urandom_range(0, 99) >= rcv_idle_pct);
        end
    end

    task automatic push_req(logic k, int unsigned t, int unsigned idv,
                            logic [IP_W-1:0] ip, int unsigned port);
        req_t r;
        r.kind        = k;
        r.now         = TIME_W'(t);
        r.id_value    = ID_W'(idv);
        r.client_ip   = ip;
        r.client_port = PORT_W'(port);
        req_backlog.push_back(r);
    endtask

    // random mix: mostly a steadily advancing clock, some arbitrary times
    task automatic random_burst(int count, int alloc_pct, int max_step);
        int unsigned span;
        int unsigned t;
        int unsigned idv;
        int          pick;
        span = (wrap_mod < 2) ? 2 : ((wrap_mod > 1024) ? 1024 : wrap_mod);
        for (int i = 0; i < count; i++)
        begin
            clock_now = (clock_now + $urandom_range(0, max_step)) % span;
            t = ($urandom_range(0, 99) < 85) ? clock_now : $urandom_range(0, 1023);
            if ($urandom_range(0, 99) < alloc_pct)
                push_req(KIND_ALLOC, t, $urandom_range(0, 65535), $urandom(),
                         $urandom_range(0, 65535));
            else
            begin
                pick = $urandom_range(0, 99);
                if (pick < 80)
                    idv = $urandom_range(1, TABLE_SIZE);
                else if (pick < 88)
                    idv = 0;
                else if (pick < 96)
                    idv = $urandom_range(TABLE_SIZE + 1, 65535);
                else
                    idv = 65535;
                push_req(KIND_LOOKUP, t, idv, $urandom(), $urandom_range(0, 65535));
            end
        end
    endtask

    // register write while the table is idle
    task automatic set_reg(logic [CFG_IDX_W-1:0] idx, int unsigned val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(val);
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_TTL)
            age_limit = val & 32'h3FF;
        else
            wrap_mod = val & 32'h7FF;
    endtask

    // hold the sender until every reply is back and the table is idle
    task automatic settle();
        while (req_backlog.size() != 0 || reply_backlog.size() != 0 || req_ch.valid)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // stimulus sequence
    initial
    begin
        for (int i = 0; i < TABLE_SIZE; i++)
        begin
            slot_busy[i]  = 1'b0;
            slot_stamp[i] = '0;
            slot_qid[i]   = '0;
            slot_ip[i]    = '0;
            slot_port[i]  = '0;
        end
        scan_ptr            = 0;
        clock_now           = 0;
        age_limit           = TTL_RESET;
        wrap_mod            = TIME_MOD_RESET;
        mismatches          = 0;
        rst_n               = 1'b0;
        cfg_we              = 1'b0;
        cfg_index           = CFG_TTL;
        cfg_data            = '0;
        hold_kick           = 1'b0;
        snd_idle_pct        = 24;
        rcv_idle_pct        = 70;
        req_ch.valid        = 1'b0;
        req_ch.kind         = KIND_ALLOC;
        req_ch.now          = '0;
        req_ch.id_value     = '0;
        req_ch.client_ip    = '0;
        req_ch.client_port  = '0;
        rsp_ch.ready        = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // directed: empty table, field extremes, out of range ids, late time
        push_req(KIND_LOOKUP, 0, 0, 32'h0, 0);
        push_req(KIND_LOOKUP, 0, 1, 32'h0, 0);
        push_req(KIND_LOOKUP, 0, 65535, 32'hFFFF_FFFF, 65535);
        push_req(KIND_ALLOC, 0, 0, 32'h0, 0);
        push_req(KIND_ALLOC, 999, 65535, 32'hFFFF_FFFF, 65535);
        push_req(KIND_LOOKUP, 3, 1, 32'h0, 0);
        push_req(KIND_LOOKUP, 3, 2, 32'h0, 0);
        push_req(KIND_LOOKUP, 3, TABLE_SIZE, 32'h0, 0);
        push_req(KIND_LOOKUP, 3, TABLE_SIZE + 1, 32'h0, 0);
        push_req(KIND_ALLOC, 1023, 16'h1234, 32'hC0A8_0001, 53);
        push_req(KIND_LOOKUP, 1023, 3, 32'h0, 0);
        push_req(KIND_ALLOC, 5, 16'hA5A5, 32'h0A00_0001, 16'h5A5A);
        push_req(KIND_ALLOC, 500, 16'h0001, 32'h7F00_0001, 1024);
        push_req(KIND_LOOKUP, 600, 1, 32'h0, 0);
        push_req(KIND_LOOKUP, 600, 5, 32'h0, 0);
        push_req(KIND_LOOKUP, 600, 0, 32'h0, 0);
        settle();

        // smallest modulus and ttl: stamps mostly below the modulus, some at or above it
        set_reg(CFG_TTL, 0);
        set_reg(CFG_TIME_MOD, 2);
        random_burst(70, 50, 3);
        settle();

        // largest ttl, modulus 1024: nothing expires, table runs full
        set_reg(CFG_TTL, 1023);
        set_reg(CFG_TIME_MOD, 1024);
        random_burst(90, 80, 4);
        settle();

        // swap idle ratios; modulus below two acts as two
        snd_idle_pct <= 70;
        rcv_idle_pct <= 24;
        set_reg(CFG_TTL, 0);
        set_reg(CFG_TIME_MOD, 0);
        random_burst(40, 60, 2);
        settle();

        set_reg(CFG_TTL, 50);
        set_reg(CFG_TIME_MOD, 1500);
        random_burst(80, 55, 6);
        settle();

        // no idling, with a long receiver stall to back up the request side
        snd_idle_pct <= 0;
        rcv_idle_pct <= 0;
        set_reg(CFG_TTL, 20);
        set_reg(CFG_TIME_MOD, 100);
        random_burst(70, 55, 5);
        @(posedge clk);
        hold_kick <= 1'b1;
        @(posedge clk);
        hold_kick <= 1'b0;
        settle();

        set_reg(CFG_TTL, 0);
        set_reg(CFG_TIME_MOD, 1);
        random_burst(40, 60, 1);
        settle();

        repeat (20) @(posedge clk);
        if (mismatches == 0 && reply_backlog.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // watchdog
    initial
    begin
        #10_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
